// ===== rtl/sprite_tile_column_expander_macros.svh =====
// Assertion helpers shared by the expander RTL.
`ifndef SPRITE_TILE_COLUMN_EXPANDER_MACROS_SVH
`define SPRITE_TILE_COLUMN_EXPANDER_MACROS_SVH

// Property holds at every rising clock edge outside reset.
`define STCE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);

// Condition must never be seen outside reset.
`define STCE_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/stce_pkg.sv =====
package stce_pkg;

	typedef enum logic [1:0] {
		REG_FLIP_SCREEN   = 2'd0,
		REG_SCREEN_WIDTH  = 2'd1,
		REG_SCREEN_HEIGHT = 2'd2
	} cfg_reg_t;

	localparam logic [9:0] SCREEN_WIDTH_RST  = 10'd320;
	localparam logic [9:0] SCREEN_HEIGHT_RST = 10'd240;
	localparam logic signed [11:0] X_SHIFT   = 12'sd32;
	localparam logic signed [11:0] TILE_PX   = 12'sd16;

	// one sprite, classified and ready for column expansion
	typedef struct packed {
		logic [15:0]        base;
		logic               descend;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic [4:0]         tiles;
		logic [3:0]         cols_m1;
		logic [5:0]         color;
		logic               mirror_x;
		logic               mirror_y;
	} cmd_t;

	// one column draw command
	typedef struct packed {
		logic [15:0]        first_code;
		logic               codes_descend;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic [4:0]         tiles_in_column;
		logic [5:0]         tile_color;
		logic               mirror_x;
		logic               mirror_y;
		logic               last_column;
	} col_t;

endpackage

// ===== rtl/sprite_tile_column_expander.sv =====
// Splits each sprite list entry into one draw command per 16-pixel tile column,
// left to right. The front end takes one entry per cycle while the command queue
// has room (disabled entries are taken and dropped); the back end then emits one
// column per cycle while out_stall is low, so an enabled sprite gives
// size_word[3:0] + 1 columns (1 to 16), and that column loop sets the sustained rate.
// With the back end idle, a taken entry is first written into the command queue
// and its first column is then loaded into the output register. Configuration writes
// are accepted every cycle (cfg_ready is always high) and should only be made
// while no sprite is in flight.
module sprite_tile_column_expander #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [9:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               sprite_enable,
	input  logic [15:0]        size_word,
	input  logic [15:0]        code_word,
	input  logic [9:0]         x_word,
	input  logic [9:0]         y_word,
	input  logic [5:0]         sprite_color,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        first_code,
	output logic               codes_descend,
	output logic signed [11:0] pos_x,
	output logic signed [11:0] pos_y,
	output logic [4:0]         tiles_in_column,
	output logic [5:0]         tile_color,
	output logic               mirror_x,
	output logic               mirror_y,
	output logic               last_column
);

	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	stce_pkg::cmd_t cmd;
	stce_pkg::cmd_t head;
	stce_pkg::col_t col;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;

	stce_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sprite_enable (sprite_enable),
		.size_word     (size_word),
		.code_word     (code_word),
		.x_word        (x_word),
		.y_word        (y_word),
		.sprite_color  (sprite_color),
		.push          (push),
		.cmd           (cmd)
	);

	stce_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	stce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.col       (col)
	);

	assign first_code      = col.first_code;
	assign codes_descend   = col.codes_descend;
	assign pos_x           = col.pos_x;
	assign pos_y           = col.pos_y;
	assign tiles_in_column = col.tiles_in_column;
	assign tile_color      = col.tile_color;
	assign mirror_x        = col.mirror_x;
	assign mirror_y        = col.mirror_y;
	assign last_column     = col.last_column;

endmodule

// ===== rtl/stce_front.sv =====
module stce_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [9:0]        cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              sprite_enable,
	input  logic [15:0]       size_word,
	input  logic [15:0]       code_word,
	input  logic [9:0]        x_word,
	input  logic [9:0]        y_word,
	input  logic [5:0]        sprite_color,
	output logic              push,
	output stce_pkg::cmd_t    cmd
);

	logic       flip_q;
	logic [9:0] width_q;
	logic [9:0] height_q;

	logic [4:0]         dimx;
	logic [4:0]         dimy;
	logic [9:0]         prod;
	logic [14:0]        code_sum;
	logic signed [11:0] sx_ext;
	logic signed [11:0] sy_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q   <= 1'b0;
			width_q  <= stce_pkg::SCREEN_WIDTH_RST;
			height_q <= stce_pkg::SCREEN_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (stce_pkg::cfg_reg_t'(cfg_index))
				stce_pkg::REG_FLIP_SCREEN:   flip_q   <= cfg_data[0];
				stce_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				stce_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dimx     = {1'b0, size_word[3:0]} + 5'd1;
	assign dimy     = {1'b0, size_word[7:4]} + 5'd1;
	assign prod     = dimx * dimy;
	// flipped codes start from the last tile of the sprite
	assign code_sum = code_word[14:0] + 15'(prod) - 15'd1;
	assign sx_ext   = {{2{x_word[9]}}, x_word};
	assign sy_ext   = {{2{y_word[9]}}, y_word};

	// disabled sprites are taken and dropped here
	assign push = in_valid && !in_stall && sprite_enable;

	always_comb begin
		cmd.descend  = flip_q;
		cmd.tiles    = dimy;
		cmd.cols_m1  = size_word[3:0];
		cmd.color    = sprite_color;
		cmd.mirror_x = size_word[12] ^ flip_q;
		cmd.mirror_y = flip_q;
		if (flip_q) begin
			cmd.base  = {size_word[8], code_sum};
			cmd.pos_x = $signed({2'b00, width_q}) - sx_ext - $signed(12'({dimx, 4'b0000}))
				- stce_pkg::X_SHIFT;
			cmd.pos_y = $signed({2'b00, height_q}) - sy_ext - $signed(12'({dimy, 4'b0000}));
		end else begin
			cmd.base  = {size_word[8], code_word[14:0]};
			cmd.pos_x = sx_ext + stce_pkg::X_SHIFT;
			cmd.pos_y = sy_ext;
		end
	end

endmodule

// ===== rtl/stce_fifo.sv =====
module stce_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stce_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output stce_pkg::cmd_t head
);

	`include "sprite_tile_column_expander_macros.svh"

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	stce_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	`STCE_NEVER(a_no_overflow, clk, arst_n, push && full && !pop, "queue overflow")
	`STCE_NEVER(a_no_underflow, clk, arst_n, pop && empty, "queue underflow")

endmodule

// ===== rtl/stce_back.sv =====
module stce_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  stce_pkg::cmd_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output stce_pkg::col_t col
);

	`include "sprite_tile_column_expander_macros.svh"

	logic               out_valid_q;
	stce_pkg::col_t     col_q;
	logic [3:0]         idx_q;
	logic [15:0]        code_q;
	logic signed [11:0] px_q;

	logic               load;
	logic               fire;
	logic               is_last;
	logic [15:0]        cur_code;
	logic signed [11:0] cur_px;

	assign load     = !out_valid_q || !out_stall;
	assign fire     = !empty && load;
	assign is_last  = idx_q == head.cols_m1;
	assign pop      = fire && is_last;
	// first column starts from the queued sprite, later ones from the running values
	assign cur_code = (idx_q == '0) ? head.base : code_q;
	assign cur_px   = (idx_q == '0) ? head.pos_x : px_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= !empty;
			end
			if (fire) begin
				idx_q <= is_last ? '0 : idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			code_q <= head.descend ? cur_code - 16'(head.tiles) : cur_code + 16'(head.tiles);
			px_q   <= cur_px + stce_pkg::TILE_PX;
			col_q.first_code      <= cur_code;
			col_q.codes_descend   <= head.descend;
			col_q.pos_x           <= cur_px;
			col_q.pos_y           <= head.pos_y;
			col_q.tiles_in_column <= head.tiles;
			col_q.tile_color      <= head.color;
			col_q.mirror_x        <= head.mirror_x;
			col_q.mirror_y        <= head.mirror_y;
			col_q.last_column     <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign col       = col_q;

	`STCE_ASSERT(a_idx_in_range, clk, arst_n, !empty |-> (idx_q <= head.cols_m1), "idx past width")
	`STCE_ASSERT(a_idle_idx_zero, clk, arst_n, empty |-> (idx_q == '0), "idx stuck while idle")

endmodule
